// ===== src/handshake_magic_deframer_macros.svh =====
// assertion helpers used by the checker file
`ifndef HANDSHAKE_MAGIC_DEFRAMER_MACROS_SVH
`define HANDSHAKE_MAGIC_DEFRAMER_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while in reset
`define HMD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/hmd_pkg.sv =====
package hmd_pkg;

	localparam int PUBKEY_BYTES  = 192;
	localparam int MAGIC_BYTES   = 32;
	localparam int MAX_PAD_BYTES = 8192;

	localparam int WORD_W      = 64;
	localparam int MAGIC_WORDS = 4;
	localparam int MAGIC_W     = WORD_W * MAGIC_WORDS;
	localparam int CFG_IDX_W   = 2;

	localparam int LIMIT = PUBKEY_BYTES + MAX_PAD_BYTES + MAGIC_BYTES;
	localparam int CNT_W = 14;

	localparam logic [CNT_W-1:0] KEY_END_C     = CNT_W'(PUBKEY_BYTES);
	localparam logic [CNT_W-1:0] MATCH_START_C = CNT_W'(PUBKEY_BYTES + MAGIC_BYTES);
	localparam logic [CNT_W-1:0] LIMIT_C       = CNT_W'(LIMIT);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAGIC_0 = 2'd0,
		CFG_MAGIC_1 = 2'd1,
		CFG_MAGIC_2 = 2'd2,
		CFG_MAGIC_3 = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_NEED_MORE   = 3'd0,
		ST_KEY_DONE    = 3'd1,
		ST_ESTABLISHED = 3'd2,
		ST_FAILED      = 3'd3,
		ST_PASSTHROUGH = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		PH_KEY   = 4'b0001,
		PH_MAGIC = 4'b0010,
		PH_EST   = 4'b0100,
		PH_FAIL  = 4'b1000
	} phase_t;

	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] consumed;
		logic [7:0]       payload;
	} result_t;

	// byte 0 of the magic sits in the top bits of word 0
	function automatic logic [7:0] magic_byte(logic [MAGIC_W-1:0] m, int unsigned i);
		return m[MAGIC_W-1-8*i -: 8];
	endfunction

endpackage

// ===== src/hmd_cfg.sv =====
module hmd_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hmd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hmd_pkg::WORD_W-1:0]        cfg_data,
	output logic [hmd_pkg::MAGIC_W-1:0]       magic
);
	import hmd_pkg::*;

	logic [WORD_W-1:0] word_q [MAGIC_WORDS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAGIC_WORDS; i++) begin
				word_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAGIC_0: word_q[0] <= cfg_data;
				CFG_MAGIC_1: word_q[1] <= cfg_data;
				CFG_MAGIC_2: word_q[2] <= cfg_data;
				CFG_MAGIC_3: word_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign magic = {word_q[0], word_q[1], word_q[2], word_q[3]};

endmodule

// ===== src/hmd_core.sv =====
module hmd_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [7:0]                  data_byte,
	input  logic                        restart,
	input  logic [hmd_pkg::MAGIC_W-1:0] magic,
	output hmd_pkg::result_t            result
);
	import hmd_pkg::*;

	phase_t           phase_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       window_q [MAGIC_BYTES];

	phase_t           ph;
	phase_t           phase_d;
	logic [CNT_W-1:0] cnt;
	logic [CNT_W-1:0] count_d;
	logic [7:0]       win_next [MAGIC_BYTES];
	logic [MAGIC_BYTES-1:0] hit;
	logic             match;
	logic             shift;

	// window as it stands once this byte is shifted in, newest last
	always_comb begin
		for (int i = 0; i < MAGIC_BYTES - 1; i++) begin
			win_next[i] = window_q[i+1];
		end
		win_next[MAGIC_BYTES-1] = data_byte;
		for (int i = 0; i < MAGIC_BYTES; i++) begin
			hit[i] = (win_next[i] == magic_byte(magic, i));
		end
	end

	assign match = &hit;

	always_comb begin
		ph      = restart ? PH_KEY : phase_q;
		cnt     = restart ? '0 : count_q;
		phase_d = ph;
		count_d = cnt;
		shift   = 1'b0;
		result  = '{status: ST_NEED_MORE, consumed: '0, payload: '0};
		unique case (ph)
			PH_KEY: begin
				count_d = cnt + 1'b1;
				if (count_d >= KEY_END_C) begin
					phase_d       = PH_MAGIC;
					result.status = ST_KEY_DONE;
				end
			end
			PH_MAGIC: begin
				shift = 1'b1;
				if (cnt <= LIMIT_C) begin
					count_d = cnt + 1'b1;
				end
				// running past the limit fails even on a matching byte
				if (count_d > LIMIT_C) begin
					phase_d       = PH_FAIL;
					result.status = ST_FAILED;
				end else if (count_d >= MATCH_START_C && match) begin
					phase_d         = PH_EST;
					result.status   = ST_ESTABLISHED;
					result.consumed = count_d;
				end
			end
			PH_EST: begin
				result.status  = ST_PASSTHROUGH;
				result.payload = data_byte;
			end
			PH_FAIL: begin
				result.status = ST_FAILED;
			end
			default: begin
				result.status = ST_FAILED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY;
			count_q <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	// stale window bytes are never compared: a match needs a full window since restart
	always_ff @(posedge clk) begin
		if (en && shift) begin
			for (int i = 0; i < MAGIC_BYTES; i++) begin
				window_q[i] <= win_next[i];
			end
		end
	end

endmodule

// ===== src/handshake_magic_deframer.sv =====
// channel   | handshake                    | payload
// ----------+------------------------------+---------------------------------------
// byte in   | byte_valid / byte_stall      | data_byte, restart
// result    | result_valid / result_stall  | status, consumed_count, payload_byte
// config    | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// one byte a cycle sustained while result_stall is low; a taken request lands in the
// input register, then the window compare and phase update fill the result register
// (result_stall can hold the request in the input register between the two)
// arst_n clears phase, count, magic words and both valid flags; the window needs no reset
// result_stall holds both stages and backs up into byte_stall when the input stage is full
// cfg_ready is always high
module handshake_magic_deframer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              byte_valid,
	output logic                              byte_stall,
	input  logic [7:0]                        data_byte,
	input  logic                              restart,
	output logic                              result_valid,
	input  logic                              result_stall,
	output hmd_pkg::status_t                  status,
	output logic [hmd_pkg::CNT_W-1:0]         consumed_count,
	output logic [7:0]                        payload_byte,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hmd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hmd_pkg::WORD_W-1:0]        cfg_data
);
	import hmd_pkg::*;

	logic               valid_s1;
	logic [7:0]         data_s1;
	logic               restart_s1;
	logic               adv;
	logic [MAGIC_W-1:0] magic;
	result_t            res;
	result_t            res_s2;

	hmd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.magic     (magic)
	);

	// result register free, or being emptied this cycle
	assign adv        = !result_valid || !result_stall;
	assign byte_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			data_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	hmd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv && valid_s1),
		.data_byte (data_s1),
		.restart   (restart_s1),
		.magic     (magic),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign status         = res_s2.status;
	assign consumed_count = res_s2.consumed;
	assign payload_byte   = res_s2.payload;

endmodule

// ===== src/hmd_checker.sv =====
`include "handshake_magic_deframer_macros.svh"

module hmd_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              result_valid,
	input  logic                              result_stall,
	input  hmd_pkg::status_t                  status,
	input  logic [hmd_pkg::CNT_W-1:0]         consumed_count,
	input  logic [7:0]                        payload_byte
);
	import hmd_pkg::*;

	`HMD_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
		result_valid && $stable(status) && $stable(consumed_count) && $stable(payload_byte),
		"stalled result changed")

	`HMD_ASSERT_NOW(a_status_code, result_valid,
		status == ST_NEED_MORE || status == ST_KEY_DONE || status == ST_ESTABLISHED ||
		status == ST_FAILED || status == ST_PASSTHROUGH,
		"status code out of range")

	`HMD_ASSERT_NOW(a_count_only_est, result_valid && status != ST_ESTABLISHED,
		consumed_count == '0, "consumed count outside established")

	`HMD_ASSERT_NOW(a_count_range, result_valid && status == ST_ESTABLISHED,
		consumed_count >= MATCH_START_C && consumed_count <= LIMIT_C,
		"established count outside magic window")

	`HMD_ASSERT_NOW(a_payload_only_pass, result_valid && status != ST_PASSTHROUGH,
		payload_byte == '0, "payload byte outside passthrough")

endmodule

bind handshake_magic_deframer hmd_checker u_hmd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.status         (status),
	.consumed_count (consumed_count),
	.payload_byte   (payload_byte)
);

// ===== test/tb_handshake_magic_deframer.sv =====
`timescale 1ns / 100ps

module tb_handshake_magic_deframer;
	import hmd_pkg::*;

	localparam int MIXED_BYTES     = 420;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef enum int {
		HS_CLEAN,
		HS_CORRUPT,
		HS_TRUNCATED,
		HS_KEY_MIMIC
	} hs_mode_t;

	// tracks the deframer state and holds one expected result per byte request
	class deframer_scoreboard;
		logic [WORD_W-1:0]  magic_words [MAGIC_WORDS];
		logic [MAGIC_W-1:0] window;
		int unsigned        count;
		phase_t             ph;
		result_t            expected_q [$];
		int unsigned        errors;
		int unsigned        results_seen;
		int unsigned        n_est;
		int unsigned        n_fail;
		int unsigned        n_pass;

		function new();
			foreach (magic_words[i])
				magic_words[i] = '0;
			window = '0;
			count = 0;
			ph = PH_KEY;
			errors = 0;
			results_seen = 0;
			n_est = 0;
			n_fail = 0;
			n_pass = 0;
		endfunction

		function void set_word(cfg_idx_t idx, logic [WORD_W-1:0] value);
			magic_words[idx] = value;
		endfunction

		function void note_byte(logic [7:0] b, logic rs);
			result_t            r;
			logic [MAGIC_W-1:0] m;
			r.status = ST_NEED_MORE;
			r.consumed = '0;
			r.payload = '0;
			m = {magic_words[CFG_MAGIC_0], magic_words[CFG_MAGIC_1],
				magic_words[CFG_MAGIC_2], magic_words[CFG_MAGIC_3]};
			if (rs) begin
				window = '0;
				count = 0;
				ph = PH_KEY;
			end
			case (ph)
				PH_KEY: begin
					count++;
					if (count >= PUBKEY_BYTES) begin
						ph = PH_MAGIC;
						r.status = ST_KEY_DONE;
					end
				end
				PH_MAGIC: begin
					window = {window[MAGIC_W-9:0], b};
					if (count <= LIMIT)
						count++;
					// passing the limit wins over a match on the same byte
					if (count > LIMIT) begin
						ph = PH_FAIL;
						r.status = ST_FAILED;
					end else if (count >= PUBKEY_BYTES + MAGIC_BYTES &&
							window[8*MAGIC_BYTES-1:0] == m[MAGIC_W-1 -: 8*MAGIC_BYTES]) begin
						ph = PH_EST;
						r.status = ST_ESTABLISHED;
						r.consumed = CNT_W'(count);
					end
				end
				PH_EST: begin
					r.status = ST_PASSTHROUGH;
					r.payload = b;
				end
				default: begin
					r.status = ST_FAILED;
				end
			endcase
			expected_q.push_back(r);
		endfunction

		function void report(string field, logic [15:0] exp_v, logic [15:0] act_v);
			errors++;
			$display("%0t %s mismatch: expected %0d, actual %0d",
				$time, field, exp_v, act_v);
		endfunction

		function void check_result(status_t st, logic [CNT_W-1:0] cc, logic [7:0] pb);
			result_t e;
			results_seen++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none, actual status %0d",
					$time, st);
				return;
			end
			e = expected_q.pop_front();
			case (e.status)
				ST_ESTABLISHED: n_est++;
				ST_FAILED:      n_fail++;
				ST_PASSTHROUGH: n_pass++;
				default:        ;
			endcase
			if (st !== e.status)
				report("status", 16'(e.status), 16'(st));
			if (cc !== e.consumed)
				report("consumed_count", 16'(e.consumed), 16'(cc));
			if (pb !== e.payload)
				report("payload_byte", 16'(e.payload), 16'(pb));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 byte_valid;
	logic                 byte_stall;
	logic [7:0]           data_byte;
	logic                 restart;
	logic                 result_valid;
	logic                 result_stall;
	status_t              status;
	logic [CNT_W-1:0]     consumed_count;
	logic [7:0]           payload_byte;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	deframer_scoreboard sb;
	logic [MAGIC_W-1:0] cur_magic;
	bit                 idle_on;
	bit                 quiet;
	bit                 hold_req;
	int unsigned        bytes_sent;
	int unsigned        handshakes;
	int unsigned        settings_used;
	int unsigned        holds_done;

	handshake_magic_deframer u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.data_byte      (data_byte),
		.restart        (restart),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.status         (status),
		.consumed_count (consumed_count),
		.payload_byte   (payload_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(status, consumed_count, payload_byte);
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
				hold_req = 1'b0;
				holds_done++;
			end else if (!quiet && idle_on && $urandom_range(0, 7) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic rs);
		if (!quiet && idle_on && $urandom_range(0, 9) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		restart <= rs;
		do @(posedge clk); while (byte_stall);
		sb.note_byte(b, rs);
		bytes_sent++;
	endtask

	task automatic wait_results();
		byte_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_magic(input logic [MAGIC_W-1:0] m);
		cfg_idx_t order [MAGIC_WORDS];
		order = '{CFG_MAGIC_0, CFG_MAGIC_1, CFG_MAGIC_2, CFG_MAGIC_3};
		cfg_valid <= 1'b1;
		foreach (order[k]) begin
			cfg_index <= order[k];
			cfg_data <= m[MAGIC_W-1-WORD_W*order[k] -: WORD_W];
			do @(posedge clk); while (!cfg_ready);
			sb.set_word(order[k], m[MAGIC_W-1-WORD_W*order[k] -: WORD_W]);
		end
		cfg_valid <= 1'b0;
		cur_magic = m;
		settings_used++;
	endtask

	task automatic change_magic(input logic [MAGIC_W-1:0] m);
		wait_results();
		write_magic(m);
	endtask

	function automatic logic [MAGIC_W-1:0] pick_magic();
		logic [MAGIC_W-1:0] m;
		for (int k = 0; k < MAGIC_W / 32; k++)
			m[32*k +: 32] = $urandom;
		case ($urandom_range(0, 5))
			0: m = '0;
			1: m = '1;
			2: m = {(MAGIC_W / 8){8'haa}};
			default: ;
		endcase
		return m;
	endfunction

	// restart, key, padding, magic, then payload bytes; truncated mode cuts the stream short
	task automatic send_handshake(input int pad, input int tail, input hs_mode_t mode);
		logic [7:0] b;
		int         magic_at;
		int         total;
		int         cut;
		int         bad;
		magic_at = PUBKEY_BYTES + pad;
		total = magic_at + MAGIC_BYTES + tail;
		cut = (mode == HS_TRUNCATED) ? $urandom_range(1, magic_at + MAGIC_BYTES - 1) : total;
		bad = $urandom_range(0, MAGIC_BYTES - 1);
		handshakes++;
		for (int i = 0; i < cut; i++) begin
			if (i >= magic_at && i < magic_at + MAGIC_BYTES) begin
				b = cur_magic[MAGIC_W-1-8*(i-magic_at) -: 8];
				if (mode == HS_CORRUPT && i - magic_at == bad)
					b = b ^ (8'h01 << $urandom_range(0, 7));
			end else if (mode == HS_KEY_MIMIC && i >= PUBKEY_BYTES - MAGIC_BYTES &&
					i < PUBKEY_BYTES) begin
				// magic inside the key must not count
				b = cur_magic[MAGIC_W-1-8*(i-PUBKEY_BYTES+MAGIC_BYTES) -: 8];
			end else begin
				b = 8'($urandom);
			end
			send_byte(b, i == 0);
		end
	endtask

	task automatic send_noise(input int n);
		repeat (n)
			send_byte(8'($urandom), $urandom_range(0, 3) == 0);
	endtask

	initial begin
		int unsigned mixed_end;
		int          pad;
		sb = new();
		arst_n = 1'b0;
		byte_valid = 1'b0;
		data_byte = '0;
		restart = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_magic = '0;
		idle_on = 1'b1;
		quiet = 1'b0;
		hold_req = 1'b0;
		bytes_sent = 0;
		handshakes = 0;
		settings_used = 0;
		holds_done = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// key-phase bytes at the field extremes, restart on and off
		write_magic({MAGIC_W{1'b1}});
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'h55, 1'b1);
		send_byte(8'haa, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'h01, 1'b1);
		send_byte(8'hff, 1'b0);
		send_noise(8);

		// earliest possible match, then magic hidden in the key
		send_handshake(0, 4, HS_CLEAN);
		send_handshake(0, 3, HS_KEY_MIMIC);
		change_magic('0);
		send_handshake(3, 3, HS_CLEAN);
		send_handshake(2, 2, HS_CORRUPT);

		mixed_end = bytes_sent + MIXED_BYTES;
		while (bytes_sent < mixed_end) begin
			idle_on = ($urandom_range(0, 3) != 0);
			pad = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
			case ($urandom_range(0, 9))
				0: send_noise($urandom_range(1, 16));
				1: change_magic(pick_magic());
				2: send_handshake(pad, $urandom_range(0, 24),
					$urandom_range(0, 1) ? HS_CORRUPT : HS_TRUNCATED);
				3: send_handshake(pad, $urandom_range(0, 24), HS_KEY_MIMIC);
				default: send_handshake(pad, $urandom_range(0, 24), HS_CLEAN);
			endcase
		end

		// receiver holds off while bytes keep coming, then the sender waits it out
		idle_on = 1'b0;
		hold_req = 1'b1;
		send_handshake(5, 40, HS_CLEAN);
		wait_results();

		quiet = 1'b1;
		change_magic(pick_magic());
		send_handshake(2, 10, HS_CLEAN);
		send_noise(10);
		wait_results();
		repeat (10) @(posedge clk);

		$display("checked %0d results from %0d bytes over %0d handshake attempts, %0d hold-offs",
			sb.results_seen, bytes_sent, handshakes, holds_done);
		$display("%0d established, %0d failed, %0d payload bytes, %0d magic settings",
			sb.n_est, sb.n_fail, sb.n_pass, settings_used);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/hmd_pkg.sv
src/hmd_cfg.sv
src/hmd_core.sv
src/handshake_magic_deframer.sv
src/hmd_checker.sv
test/tb_handshake_magic_deframer.sv
